// ----- src/cnsl_pkg.sv -----
package cnsl_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_ACC,
        ST_DONE,
        ST_CLEAR
    } state_t;

    // Grid and count sizes are fixed by the port widths.
    localparam int MAX_DIM    = 16;
    localparam int CELLS      = 4096;
    localparam int MAX_LEVEL  = 8;
    localparam int COUNT_BITS = 16;

    localparam logic [2:0] REG_DIM_X  = 3'd0;
    localparam logic [2:0] REG_DIM_Y  = 3'd1;
    localparam logic [2:0] REG_DIM_Z  = 3'd2;
    localparam logic [2:0] REG_TARGET = 3'd3;
    localparam logic [2:0] REG_LIMIT  = 3'd4;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

// ----- src/cube_neighborhood_search_level.sv -----
// A load word passes through ST_CHECK, and the block is back in ST_IDLE before it takes the next word.
// A query walks the cube of each level from level 0 up, one cell a cycle on the single memory
// read port, with an ST_ACC step after each level; an off-grid cell goes straight from ST_CHECK
// to ST_DONE, and an empty cell stops after level 0. The result is registered on leaving ST_DONE,
// and the next word is taken only after that, later if the previous result still waits.
// After aresetn is released the count store is cleared, one entry a cycle, across all CELLS (4096)
// entries; no word is accepted meanwhile, configuration writes are.
module cube_neighborhood_search_level
    import cnsl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: cell_x[3:0], cell_y[7:4], cell_z[11:8], point_count[27:12], zero fill
    input  logic [31:0] s_tdata,
    // tuser: mode
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: search_level[3:0], cell_empty[4], out_of_grid[5], zero fill
    output logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int AW = $clog2(CELLS);
    localparam int IW = AW + 1;          // raster index with room for the range check
    localparam int PW = $clog2(MAX_DIM); // coordinate bits of an in-grid cell
    localparam int LW = 6;               // level counter width
    localparam int CW = 8;               // signed coordinate width

    // Configuration registers.
    logic [4:0]  dim_x_reg, dim_y_reg, dim_z_reg;
    logic [15:0] target_reg;
    logic [3:0]  limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_x_reg  <= 5'd16;
            dim_y_reg  <= 5'd16;
            dim_z_reg  <= 5'd16;
            target_reg <= 16'd8;
            limit_reg  <= 4'd8;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DIM_X:  dim_x_reg  <= cfg_data[4:0];
                REG_DIM_Y:  dim_y_reg  <= cfg_data[4:0];
                REG_DIM_Z:  dim_z_reg  <= cfg_data[4:0];
                REG_TARGET: target_reg <= cfg_data;
                REG_LIMIT:  limit_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Effective dimensions, saturated into 1..MAX_DIM.
    function automatic logic [4:0] eff(input logic [4:0] d);
        logic [4:0] r;
        r = d;
        if (d == 5'd0) r = 5'd1;
        if (32'(d) > MAX_DIM) r = 5'(MAX_DIM);
        return r;
    endfunction

    logic [4:0] ex, ey, ez;
    logic [9:0] dim_yz;
    assign ex = eff(dim_x_reg);
    assign ey = eff(dim_y_reg);
    assign ez = eff(dim_z_reg);
    // The y-z plane size depends only on configuration, so the per-cell index
    // needs two independent small products instead of a dependent pair.
    assign dim_yz = 10'(ey) * 10'(ez);

    logic [LW-1:0] limit_eff;
    assign limit_eff = (32'(limit_reg) > MAX_LEVEL) ? LW'(MAX_LEVEL) : LW'(limit_reg);

    state_t state_reg, state_next;
    logic [AW:0]   clr_reg;
    logic          mode_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [CW-1:0] ox_reg, oy_reg, oz_reg;
    logic [LW-1:0] lvl_reg;
    logic [15:0]   cnt_reg;
    logic [32:0]   sum_reg;
    logic          rd_ok_reg;
    logic          empty_reg;
    logic          off_reg;
    logic          res_valid_reg;
    logic [7:0]    res_reg;

    // The cell visited now and its raster index.
    logic signed [CW-1:0] px, py, pz;
    logic          p_in;
    logic [IW-1:0] p_idx;
    logic          p_ok;
    always_comb begin
        px = cx_reg + ox_reg;
        py = cy_reg + oy_reg;
        pz = cz_reg + oz_reg;
        p_in = !px[CW-1] && !py[CW-1] && !pz[CW-1] &&
               (px < $signed({3'b000, ex})) && (py < $signed({3'b000, ey})) &&
               (pz < $signed({3'b000, ez}));
        p_idx = IW'(px[PW-1:0]) * IW'(dim_yz) + IW'(py[PW-1:0]) * IW'(ez) +
                IW'(pz[PW-1:0]);
        p_ok = p_in && (p_idx < IW'(CELLS));
    end

    // Count store.
    logic [COUNT_BITS-1:0] mem [CELLS];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[p_idx[AW-1:0]];
    end

    logic s_fire;
    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    logic signed [CW-1:0] neg_lvl;
    logic signed [CW-1:0] neg_lvl_up;
    assign neg_lvl    = -$signed({2'b00, lvl_reg});
    assign neg_lvl_up = -$signed({2'b00, lvl_reg + LW'(1)});

    // The read issued in the previous cycle is added only when it belonged to
    // the walk and hit a stored cell.
    logic [32:0] sum_add;
    logic [32:0] sum_sat;
    always_comb begin
        sum_add = sum_reg + (rd_ok_reg ? 33'(rd_data_reg) : 33'd0);
        sum_sat = sum_add[32] ? 33'h0FFFFFFFF : sum_add;
    end

    logic last_cell;
    assign last_cell = (ox_reg == $signed({2'b00, lvl_reg})) &&
                       (oy_reg == $signed({2'b00, lvl_reg})) &&
                       (oz_reg == $signed({2'b00, lvl_reg}));

    // At the end of a level the full cube sum is known. An empty center shows
    // as a zero sum at level 0; otherwise the search ends at the limit level or
    // once the sum reaches the target plus one.
    logic enough;
    logic center_zero;
    logic level_stop;
    assign enough      = (sum_sat >= 33'(target_reg) + 33'd1);
    assign center_zero = (lvl_reg == '0) && (sum_sat == 33'd0);
    assign level_stop  = center_zero || (lvl_reg >= limit_eff) || enough;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == (AW+1)'(CELLS - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_fire) state_next = ST_CHECK;
            ST_CHECK: begin
                if (mode_reg == MODE_WRITE) state_next = ST_IDLE;
                else if (!p_in) state_next = ST_DONE;
                else state_next = ST_WALK;
            end
            ST_WALK:  if (last_cell) state_next = ST_ACC;
            ST_ACC:   state_next = level_stop ? ST_DONE : ST_WALK;
            ST_DONE:  if (!res_valid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Store write port: clearing sweep or a load word.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = p_idx[AW-1:0];
        wr_data = COUNT_BITS'(cnt_reg);
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_reg[AW-1:0];
            wr_data = '0;
        end else if (state_reg == ST_CHECK && mode_reg == MODE_WRITE && p_ok) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (m_tvalid && m_tready) res_valid_reg <= 1'b0;
            if (state_reg == ST_DONE && state_next == ST_IDLE) res_valid_reg <= 1'b1;
        end
    end

    // Payload and walk registers.
    always_ff @(posedge aclk) begin
        rd_ok_reg <= p_ok && (state_reg == ST_WALK);
        case (state_reg)
            ST_IDLE: begin
                mode_reg  <= s_tuser;
                cx_reg    <= CW'(s_tdata[3:0]);
                cy_reg    <= CW'(s_tdata[7:4]);
                cz_reg    <= CW'(s_tdata[11:8]);
                cnt_reg   <= s_tdata[27:12];
                ox_reg    <= '0;
                oy_reg    <= '0;
                oz_reg    <= '0;
                lvl_reg   <= '0;
                sum_reg   <= '0;
                empty_reg <= 1'b0;
                off_reg   <= 1'b0;
            end
            ST_CHECK: begin
                if (!p_in) off_reg <= 1'b1;
            end
            ST_WALK: begin
                // Add the cell read last cycle and step z fastest, then y, then x.
                sum_reg <= sum_sat;
                if (oz_reg != $signed({2'b00, lvl_reg})) begin
                    oz_reg <= oz_reg + CW'(1);
                end else begin
                    oz_reg <= neg_lvl;
                    if (oy_reg != $signed({2'b00, lvl_reg})) begin
                        oy_reg <= oy_reg + CW'(1);
                    end else begin
                        oy_reg <= neg_lvl;
                        ox_reg <= ox_reg + CW'(1);
                    end
                end
            end
            ST_ACC: begin
                if (center_zero) begin
                    empty_reg <= 1'b1;
                end else if (!level_stop) begin
                    // Start the next cube from its lowest corner with a fresh sum.
                    lvl_reg <= lvl_reg + LW'(1);
                    ox_reg  <= neg_lvl_up;
                    oy_reg  <= neg_lvl_up;
                    oz_reg  <= neg_lvl_up;
                    sum_reg <= '0;
                end
            end
            ST_DONE: begin
                if (state_next == ST_IDLE)
                    res_reg <= {2'b00, off_reg, empty_reg, lvl_reg[3:0]};
            end
            default: ;
        endcase
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = res_reg;
endmodule

// ----- tb/cube_neighborhood_search_level_test.sv -----
// Testbench for the cube neighborhood search level block.
// Load words write cell counts into the grid. Query words return the cube
// level that the block picks for the named cell. A predictor that runs inside
// the bench tracks the grid and the registers, and it works out the reply for
// every query word that the block accepts. A monitor process compares each
// reply word with the oldest prediction still waiting.
module cube_neighborhood_search_level_test;
    import cnsl_pkg::*;

    localparam int GRID_SIDE = 16;
    localparam int GRID_CELLS = 4096;
    localparam int TOP_LEVEL = 8;

    typedef struct packed {
        logic [3:0] level;
        logic       empty;
        logic       off_grid;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_DIM_X;
    logic [15:0] cfg_data = '0;

    // This is the bench's own copy of the grid and of the registers.
    logic [15:0] grid_counts [GRID_CELLS];
    logic [4:0]  cur_dim [3];
    logic [15:0] cur_target;
    logic [3:0]  cur_limit;

    reply_t pending_replies [$];
    int     mismatches = 0;
    int     hold_cycles = 0;   // The reply side holds off for this many cycles once.
    bit     calm = 1'b0;       // When this is set, neither side idles.

    always #6 aclk = ~aclk;

    cube_neighborhood_search_level DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // A dimension register reads as 1 when it is 0, and as 16 when it is
    // above 16.
    function automatic int eff_dim(input logic [4:0] d);
        if (d == 0) return 1;
        if (d > GRID_SIDE) return GRID_SIDE;
        return int'(d);
    endfunction

    function automatic bit cell_in_grid(input int x, input int y, input int z);
        return x >= 0 && y >= 0 && z >= 0 && x < eff_dim(cur_dim[0])
            && y < eff_dim(cur_dim[1]) && z < eff_dim(cur_dim[2]);
    endfunction

    // This is the raster address. An address of GRID_CELLS or more is not
    // backed by the store.
    function automatic int cell_slot(input int x, input int y, input int z);
        return (x * eff_dim(cur_dim[1]) + y) * eff_dim(cur_dim[2]) + z;
    endfunction

    function automatic longint cell_count(input int x, input int y, input int z);
        int slot;
        if (!cell_in_grid(x, y, z)) return 0;
        slot = cell_slot(x, y, z);
        if (slot >= GRID_CELLS) return 0;
        return longint'(grid_counts[slot]);
    endfunction

    function automatic longint cube_total(input int cx, input int cy, input int cz,
                                          input int half);
        longint total;
        total = 0;
        for (int x = cx - half; x <= cx + half; x++)
            for (int y = cy - half; y <= cy + half; y++)
                for (int z = cz - half; z <= cz + half; z++) begin
                    total += cell_count(x, y, z);
                    if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
                end
        return total;
    endfunction

    function automatic reply_t predict_query(input int x, input int y, input int z);
        reply_t r;
        int lim;
        int lvl;
        longint want;
        longint total;
        r = '0;
        if (!cell_in_grid(x, y, z)) begin
            r.off_grid = 1'b1;
            return r;
        end
        if (cell_count(x, y, z) == 0) begin
            r.empty = 1'b1;
            return r;
        end
        lim = (cur_limit > TOP_LEVEL) ? TOP_LEVEL : int'(cur_limit);
        want = longint'(cur_target) + 1;
        lvl = 0;
        total = cube_total(x, y, z, 0);
        while (lvl < lim && total < want) begin
            lvl++;
            total = cube_total(x, y, z, lvl);
        end
        r.level = lvl[3:0];
        return r;
    endfunction

    // This sends one word. The predictor is updated at the moment the word is
    // accepted.
    task automatic send_word(input logic mode, input logic [3:0] x, input logic [3:0] y,
                             input logic [3:0] z, input logic [15:0] cnt);
        int gap;
        int slot;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'd0, cnt, z, y, x};
        do @(posedge aclk); while (!s_tready);
        if (mode == MODE_WRITE) begin
            if (cell_in_grid(x, y, z)) begin
                slot = cell_slot(x, y, z);
                if (slot < GRID_CELLS) grid_counts[slot] = cnt;
            end
        end else begin
            pending_replies.push_back(predict_query(x, y, z));
        end
    endtask

    // This waits until every reply has arrived. A trailing load word may
    // still be in progress at that point, so the task waits on before it returns.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // This writes all five registers back to back. Valid stays high across the
    // writes, so it is never lowered and raised again in the same step.
    task automatic set_config(input logic [15:0] dx, input logic [15:0] dy,
                              input logic [15:0] dz, input logic [15:0] tgt,
                              input logic [15:0] lim);
        logic [15:0] vals [5];
        logic [2:0]  idx [5];
        vals = '{dx, dy, dz, tgt, lim};
        idx  = '{REG_DIM_X, REG_DIM_Y, REG_DIM_Z, REG_TARGET, REG_LIMIT};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_dim[0] = dx[4:0];
        cur_dim[1] = dy[4:0];
        cur_dim[2] = dz[4:0];
        cur_target = tgt;
        cur_limit  = lim[3:0];
    endtask

    // This is the reply side. It stalls at random, and once it holds off for
    // a long stretch when the pressure test asks for it.
    initial begin : reply_monitor
        int gap;
        reply_t want;
        @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            gap = calm ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply word %h", m_tdata);
            end else begin
                want = pending_replies.pop_front();
                if (m_tdata[3:0] !== want.level || m_tdata[4] !== want.empty
                        || m_tdata[5] !== want.off_grid || m_tdata[7:6] !== 2'b00) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply mismatch: expected level %0d empty %0b off %0b, got %h",
                                 want.level, want.empty, want.off_grid, m_tdata);
                end
            end
        end
    end

    // After reset every cell reads as empty, and corner cells hit no edge trouble.
    task automatic test_reset_state();
        send_word(MODE_QUERY, 4'd0, 4'd0, 4'd0, 16'd0);
        send_word(MODE_QUERY, 4'd15, 4'd15, 4'd15, 16'hFFFF);
        send_word(MODE_QUERY, 4'd7, 4'd8, 4'd3, 16'd0);
        drain();
    endtask

    // These are the field extremes and the special cases: a saturated dimension,
    // a zero dimension, a limit above the top level, writes and queries off
    // the grid, a full search, and both target extremes.
    task automatic test_directed();
        set_config(16'd16, 16'd16, 16'd16, 16'd0, 16'd2);
        send_word(MODE_WRITE, 4'd0, 4'd0, 4'd0, 16'hFFFF);
        send_word(MODE_WRITE, 4'd15, 4'd15, 4'd15, 16'd1);
        send_word(MODE_WRITE, 4'd1, 4'd1, 4'd1, 16'd3);
        send_word(MODE_QUERY, 4'd0, 4'd0, 4'd0, 16'd0);
        send_word(MODE_QUERY, 4'd15, 4'd15, 4'd15, 16'd0);
        drain();
        set_config(16'd4, 16'd5, 16'd3, 16'hFFFF, 16'd15);
        send_word(MODE_WRITE, 4'd9, 4'd1, 4'd1, 16'd5);
        send_word(MODE_QUERY, 4'd9, 4'd1, 4'd1, 16'd0);
        send_word(MODE_QUERY, 4'd0, 4'd0, 4'd0, 16'd0);
        send_word(MODE_QUERY, 4'd3, 4'd4, 4'd2, 16'd0);
        drain();
        set_config(16'd0, 16'd31, 16'd17, 16'd65534, 16'd8);
        send_word(MODE_WRITE, 4'd0, 4'd3, 4'd3, 16'd9);
        send_word(MODE_QUERY, 4'd0, 4'd3, 4'd3, 16'd0);
        send_word(MODE_QUERY, 4'd1, 4'd0, 4'd0, 16'd0);
        drain();
        set_config(16'd2, 16'd2, 16'd2, 16'd1, 16'd0);
        send_word(MODE_WRITE, 4'd1, 4'd1, 4'd1, 16'd1);
        send_word(MODE_QUERY, 4'd1, 4'd1, 4'd1, 16'd0);
        send_word(MODE_QUERY, 4'd1, 4'd1, 4'd0, 16'd0);
        drain();
    endtask

    task automatic test_random_phases();
        int lim;
        int n;
        logic [3:0] x, y, z;
        logic [15:0] cnt;
        for (int phase = 0; phase < 10; phase++) begin
            lim = (phase % 4 == 3) ? $urandom_range(4, 15) : $urandom_range(0, 3);
            set_config(16'($urandom_range(0, 31)), 16'($urandom_range(0, 31)),
                       16'($urandom_range(0, 31)),
                       (phase % 3 == 0) ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(0, 40)),
                       16'(lim));
            calm = (phase == 5);
            // Large limits make each query walk many cells, so those phases stay short.
            n = (lim > 3) ? 12 : 52;
            for (int i = 0; i < n; i++) begin
                x = 4'($urandom_range(0, 15));
                y = 4'($urandom_range(0, 15));
                z = 4'($urandom_range(0, 15));
                if ($urandom_range(0, 3) != 0) begin
                    if (x >= eff_dim(cur_dim[0])) x = 4'(x % eff_dim(cur_dim[0]));
                    if (y >= eff_dim(cur_dim[1])) y = 4'(y % eff_dim(cur_dim[1]));
                    if (z >= eff_dim(cur_dim[2])) z = 4'(z % eff_dim(cur_dim[2]));
                end
                case ($urandom_range(0, 3))
                    0: cnt = 16'd0;
                    1: cnt = 16'hFFFF;
                    default: cnt = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
                endcase
                send_word(1'($urandom_range(0, 1)), x, y, z, cnt);
            end
            drain();
            calm = 1'b0;
        end
    endtask

    // The reply side stops for a long while and queries keep coming, so the
    // block fills up and holds its input off.
    task automatic test_backpressure();
        set_config(16'd8, 16'd8, 16'd8, 16'd3, 16'd0);
        send_word(MODE_WRITE, 4'd2, 4'd2, 4'd2, 16'd4);
        hold_cycles = 400;
        for (int i = 0; i < 30; i++)
            send_word(MODE_QUERY, 4'd2, 4'd2, 4'($urandom_range(0, 15)), 16'd0);
        drain();
    endtask

    initial begin : timeout_guard
        #(12 * 4_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : main_flow
        for (int i = 0; i < GRID_CELLS; i++) grid_counts[i] = '0;
        cur_dim = '{5'd16, 5'd16, 5'd16};
        cur_target = 16'd8;
        cur_limit = 4'd8;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_directed();
        test_random_phases();
        test_backpressure();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
